/* sv/lkvt_pkg.sv */
// Package: sizes, operation codes, sequencer states and shared structs for the key/value table.
`default_nettype none
package lkvt_pkg;
    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        K_SET = 3'd0,
        K_GET = 3'd1,
        K_DEL = 3'd2,
        K_CLR = 3'd3,
        K_GOI = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  rd_en;
        logic [IDX_BITS-1:0]   rd_addr;
        logic                  wr_en;
        logic [IDX_BITS-1:0]   wr_addr;
        logic [KEY_BITS-1:0]   wr_key;
        logic [VALUE_BITS-1:0] wr_val;
    } t_mem_req;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] value;
        logic [CNT_BITS-1:0]   count;
        logic                  status;
    } t_result;
endpackage
`default_nettype wire

/* sv/lkvt_store.sv */
// Entry store: key and value memories, one write port and one registered read port.
`default_nettype none
module lkvt_store (
    input  wire logic                          i_clk,
    input  wire lkvt_pkg::t_mem_req            i_req,
    output logic [lkvt_pkg::KEY_BITS-1:0]      o_rd_key,
    output logic [lkvt_pkg::VALUE_BITS-1:0]    o_rd_val
);
    import lkvt_pkg::*;

    logic [KEY_BITS-1:0]   r_key_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_val_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_key_mem[i_req.wr_addr] <= i_req.wr_key;
            r_val_mem[i_req.wr_addr] <= i_req.wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_key <= r_key_mem[i_req.rd_addr];
            o_rd_val <= r_val_mem[i_req.rd_addr];
        end
    end
endmodule
`default_nettype wire

/* sv/lkvt_seq.sv */
// Sequencer: linear key search with one shared comparator, append, and shift-down on delete.
`default_nettype none
module lkvt_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [2:0]                    i_kind,
    input  wire logic [lkvt_pkg::KEY_BITS-1:0] i_key,
    input  wire logic [lkvt_pkg::VALUE_BITS-1:0] i_value,
    output lkvt_pkg::t_mem_req                 o_req,
    input  wire logic [lkvt_pkg::KEY_BITS-1:0] i_rd_key,
    input  wire logic [lkvt_pkg::VALUE_BITS-1:0] i_rd_val,
    output logic                               o_res_valid,
    input  wire logic                          i_res_take,
    output lkvt_pkg::t_result                  o_res
);
    import lkvt_pkg::*;

    t_state                r_state, n_state;
    logic [2:0]            r_kind, n_kind;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [CNT_BITS-1:0]   r_idx, n_idx;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [IDX_BITS-1:0]   r_cmp_idx, n_cmp_idx;
    logic [IDX_BITS-1:0]   r_wr_addr, n_wr_addr;
    logic                  r_wr_pend, n_wr_pend;
    logic                  r_res_found, n_res_found;
    logic [VALUE_BITS-1:0] r_res_val, n_res_val;
    logic                  r_res_status, n_res_status;
    logic                  hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_wr_pend <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_wr_addr    <= n_wr_addr;
        r_res_found  <= n_res_found;
        r_res_val    <= n_res_val;
        r_res_status <= n_res_status;
    end

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_key        = r_key;
        n_val        = r_val;
        n_idx        = r_idx;
        n_count      = r_count;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_wr_addr    = r_wr_addr;
        n_wr_pend    = r_wr_pend;
        n_res_found  = r_res_found;
        n_res_val    = r_res_val;
        n_res_status = r_res_status;
        o_req         = '0;
        o_req.rd_addr = r_idx[IDX_BITS-1:0];
        hit           = r_cmp_vld && (i_rd_key == r_key);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind       = i_kind;
                    n_key        = i_key;
                    n_val        = i_value;
                    n_idx        = '0;
                    n_cmp_vld    = 1'b0;
                    n_res_found  = 1'b0;
                    n_res_val    = '0;
                    n_res_status = 1'b0;
                    case (i_kind)
                        K_CLR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        K_SET, K_GET, K_DEL, K_GOI: n_state = S_SEARCH;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_cmp_vld   = 1'b0;
                    n_res_found = 1'b1;
                    case (r_kind)
                        K_SET: begin
                            o_req.wr_en   = 1'b1;
                            o_req.wr_addr = r_cmp_idx;
                            o_req.wr_key  = r_key;
                            o_req.wr_val  = r_val;
                            n_res_val     = r_val;
                            n_state       = S_DONE;
                        end
                        K_DEL: begin
                            n_res_val = i_rd_val;
                            n_wr_addr = r_cmp_idx;
                            n_wr_pend = 1'b0;
                            n_state   = S_SHIFT;
                        end
                        default: begin
                            n_res_val = i_rd_val;
                            n_state   = S_DONE;
                        end
                    endcase
                end else if (r_idx < r_count) begin
                    o_req.rd_en = 1'b1;
                    n_cmp_idx   = r_idx[IDX_BITS-1:0];
                    n_idx       = r_idx + CNT_BITS'(1);
                    n_cmp_vld   = 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                    n_state   = S_DONE;
                    if (r_kind == K_SET || r_kind == K_GOI) begin
                        if (r_count < CNT_BITS'(CAPACITY)) begin
                            o_req.wr_en   = 1'b1;
                            o_req.wr_addr = r_count[IDX_BITS-1:0];
                            o_req.wr_key  = r_key;
                            o_req.wr_val  = (r_kind == K_SET) ? r_val : '0;
                            n_res_val     = (r_kind == K_SET) ? r_val : '0;
                            n_count       = r_count + CNT_BITS'(1);
                        end else begin
                            n_res_status = 1'b1;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // read place idx while writing the previous word one place down
                if (r_wr_pend) begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_addr = r_wr_addr;
                    o_req.wr_key  = i_rd_key;
                    o_req.wr_val  = i_rd_val;
                    n_wr_addr     = r_wr_addr + IDX_BITS'(1);
                end
                if (r_idx < r_count) begin
                    o_req.rd_en = 1'b1;
                    n_idx       = r_idx + CNT_BITS'(1);
                    n_wr_pend   = 1'b1;
                end else begin
                    n_wr_pend = 1'b0;
                    if (!r_wr_pend) begin
                        n_count = r_count - CNT_BITS'(1);
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.found  = r_res_found;
    assign o_res.value  = r_res_val;
    assign o_res.count  = r_count;
    assign o_res.status = r_res_status;
endmodule
`default_nettype wire

/* sv/linear_key_value_table_top.sv */
// Top level: key/value table with sequencer, entry store and output register.
//
// Input channel i_in_valid/o_in_ready carries one request word: i_kind (set, get,
// delete, clear, get-or-insert), i_key and i_value_in. Output channel
// o_out_valid/i_out_ready carries one result word per request: o_found,
// o_value_out, o_entry_count and o_status (table full, append refused).
// One request is handled at a time; o_in_ready is low while it is in work.
// A search reads one entry per cycle through the single read port of the
// entry store and checks the registered read data on the one key comparator.
// With n live entries, a hit stops the search at the matching place, a miss
// reads all n entries first, and clear and unknown kinds go straight to the
// result. A delete hit then moves the later entries down one place per cycle.
// The next request is taken in the cycle after the result word is registered.
// The result goes into an output register, so the next request is taken
// while a result waits; a stalled receiver holds that word and finally
// holds the sequencer in its finishing step. Synchronous reset empties the
// table (count zero) and drops any pending result; stored entries are not
// cleared and are never read until written.
`default_nettype none
module linear_key_value_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_value_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [31:0]      o_value_out,
    output logic [4:0]       o_entry_count,
    output logic             o_status
);
    import lkvt_pkg::*;

    t_mem_req              mem_req;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  res_valid;
    logic                  res_take;
    t_result               res;
    logic                  r_o_vld;
    t_result               r_o_res;

    lkvt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_key       (KEY_BITS'(i_key)),
        .i_value     (VALUE_BITS'(i_value_in)),
        .o_req       (mem_req),
        .i_rd_key    (rd_key),
        .i_rd_val    (rd_val),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    lkvt_store u_store (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_rd_key (rd_key),
        .o_rd_val (rd_val)
    );

    assign res_take = res_valid && (!r_o_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (res_take) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_o_res <= res;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_found       = r_o_res.found;
    assign o_value_out   = 32'(r_o_res.value);
    assign o_entry_count = 5'(r_o_res.count);
    assign o_status      = r_o_res.status;
endmodule
`default_nettype wire

/* sv/lkvt_checker.sv */
// Checker: port-level assertions on the key/value table, bound to the top level.
`default_nettype none
module lkvt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_found,
    input wire logic [31:0] o_value_out,
    input wire logic [4:0]  o_entry_count,
    input wire logic        o_status
);
    import lkvt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word pending after reset");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= 5'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |->
            !o_found && o_value_out == 32'd0 && o_entry_count == 5'(CAPACITY))
        else $error("refused append on a table that is not full");

    a_found_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> !o_status)
        else $error("found and refused together");
endmodule

bind linear_key_value_table_top lkvt_checker u_lkvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_found       (o_found),
    .o_value_out   (o_value_out),
    .o_entry_count (o_entry_count),
    .o_status      (o_status)
);
`default_nettype wire

/* dv/tb_linear_key_value_table_top.sv */
// Testbench for the linear key/value table: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module tb_linear_key_value_table_top;
    import lkvt_pkg::*;

    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
    localparam logic [31:0] KEY_ALL_ONES     = 32'hFFFF_FFFF;
    localparam int RANDOM_WORDS = 1800;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400_000;

    // Tracks table contents and queues the expected result word for each request.
    class kv_table_tracker;
        logic [KEY_BITS-1:0]   keys [CAPACITY];
        logic [VALUE_BITS-1:0] vals [CAPACITY];
        int      live;
        t_result pending [$];
        int      errors;
        int      checked;
        int      refused;
        int      hits;

        function void note_request(logic [2:0] kind, logic [31:0] key, logic [31:0] value_in);
            t_result r;
            int      at;
            int      i;
            r  = '0;
            at = -1;
            for (i = 0; i < live; i++) begin
                if (at < 0 && keys[i] == key) at = i;
            end
            case (kind)
                K_SET, K_GOI: begin
                    if (at >= 0) begin
                        r.found = 1'b1;
                        if (kind == K_SET) vals[at] = value_in;
                        r.value = vals[at];
                    end else if (live < CAPACITY) begin
                        keys[live] = key;
                        vals[live] = (kind == K_SET) ? value_in : '0;
                        r.value    = vals[live];
                        live++;
                    end else begin
                        r.status = 1'b1;
                        refused++;
                    end
                end
                K_GET: begin
                    if (at >= 0) begin
                        r.found = 1'b1;
                        r.value = vals[at];
                    end
                end
                K_DEL: begin
                    if (at >= 0) begin
                        r.found = 1'b1;
                        r.value = vals[at];
                        for (i = at; i + 1 < live; i++) begin
                            keys[i] = keys[i + 1];
                            vals[i] = vals[i + 1];
                        end
                        live--;
                    end
                end
                K_CLR: live = 0;
                default: ;
            endcase
            if (r.found) hits++;
            r.count = CNT_BITS'(live);
            pending.push_back(r);
        endfunction

        function void check_result(logic found, logic [31:0] value, logic [4:0] count,
                                   logic status);
            t_result want;
            if (pending.size() == 0) begin
                $error("result word with nothing outstanding: found %0d value %h count %0d status %0d",
                       found, value, count, status);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, found);
                errors++;
            end
            if (value !== want.value) begin
                $error("value_out: expected %h, got %h", want.value, value);
                errors++;
            end
            if (count !== want.count) begin
                $error("entry_count: expected %0d, got %0d", want.count, count);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_kind      = '0;
    logic [31:0] i_key       = '0;
    logic [31:0] i_value_in  = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_found;
    logic [31:0] o_value_out;
    logic [4:0]  o_entry_count;
    logic        o_status;

    kv_table_tracker book;
    int sent_words  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;
    bit rx_hold     = 1'b0;

    linear_key_value_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_value_in    (i_value_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_linear_key_value_table_top NOT OK");
            $finish;
        end
    end

    // Result side: check on handshake, then pick ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_result(o_found, o_value_out, o_entry_count, o_status);
        if (rx_hold)
            i_out_ready <= 1'b0;
        else if (calm)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(99) >= 36);
    end

    // Long receiver hold-off so the table backs up and stalls its input.
    initial begin
        wait (sent_words >= HOLD_AT);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic send_word(logic [2:0] kind, logic [31:0] key, logic [31:0] value_in);
        if (!calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        i_value_in <= value_in;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_request(kind, key, value_in);
        sent_words++;
    endtask

    initial begin
        int          i;
        int          useful;
        int          pool_n;
        int          r;
        logic [31:0] pool [32];
        logic [2:0]  kind;
        logic [31:0] key;
        logic [31:0] value;

        book = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-table misses, extremes, fill to capacity, refusals, shifts, clear
        send_word(K_GET, '0, '0);
        send_word(K_DEL, KEY_ALL_ONES, KEY_ALL_ONES);
        send_word(K_SET, '0, KEY_ALL_ONES);
        send_word(K_SET, KEY_ALL_ONES, '0);
        send_word(K_GOI, '0, 32'h1357_9BDF);
        send_word(K_GOI, 32'h1234_5678, KEY_ALL_ONES);
        for (i = 1; i <= CAPACITY - 3; i++)
            send_word(K_SET, 32'h0101_0101 * i, $urandom);
        send_word(K_SET, 32'hDEAD_BEEF, 32'h0F0F_0F0F);
        send_word(K_GOI, 32'hCAFE_F00D, '0);
        send_word(K_SET, KEY_ALL_ONES, 32'h5A5A_A5A5);
        send_word(K_GET, KEY_ALL_ONES, '0);
        send_word(K_DEL, '0, '0);
        send_word(K_DEL, 32'h0101_0101 * (CAPACITY - 3), '0);
        send_word(KIND_UNUSED_FIRST, 32'h1234_5678, KEY_ALL_ONES);
        send_word(K_CLR, KEY_ALL_ONES, KEY_ALL_ONES);
        send_word(KIND_UNUSED_LAST, '0, '0);

        // random: small key pools so hits, deletes and full-table refusals are common
        useful = 0;
        pool_n = 0;
        while (useful < RANDOM_WORDS) begin
            if (useful % 150 == 0) begin
                pool_n = $urandom_range(24, 4);
                for (i = 0; i < pool_n; i++) begin
                    r = $urandom_range(15);
                    pool[i] = (r == 0) ? '0 : (r == 1) ? KEY_ALL_ONES : $urandom;
                end
            end
            calm <= (useful >= 700 && useful < 1000);
            r = $urandom_range(99);
            if (r < 34)      kind = K_SET;
            else if (r < 53) kind = K_GET;
            else if (r < 69) kind = K_DEL;
            else if (r < 94) kind = K_GOI;
            else if (r < 96) kind = K_CLR;
            else             kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
            key = ($urandom_range(99) < 94) ? pool[$urandom_range(pool_n - 1)] : $urandom;
            r = $urandom_range(19);
            value = (r == 0) ? '0 : (r == 1) ? KEY_ALL_ONES : $urandom;
            send_word(kind, key, value);
            if (kind <= K_GOI) useful++;
        end
        i_in_valid <= 1'b0;
        calm       <= 1'b0;

        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d result words checked, %0d hits, %0d full-table refusals",
                 sent_words, book.checked, book.hits, book.refused);
        $display("all five operations, unused kinds, a %0d-cycle output hold-off, idle-free stretch",
                 HOLD_CYCLES);
        if (book.errors == 0 && book.pending.size() == 0)
            $display("tb_linear_key_value_table_top OK");
        else
            $display("tb_linear_key_value_table_top NOT OK");
        $finish;
    end
endmodule

/* filelist.f */
sv/lkvt_pkg.sv
sv/lkvt_store.sv
sv/lkvt_seq.sv
sv/linear_key_value_table_top.sv
sv/lkvt_checker.sv
dv/tb_linear_key_value_table_top.sv
